FILE: hw/rtl/set_assoc_lru_cache_directory_unit_defines.svh
// Assertion macros shared by the cache directory RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef SET_ASSOC_LRU_CACHE_DIRECTORY_UNIT_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_DIRECTORY_UNIT_DEFINES_SVH

// same-cycle implication
`define SACD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SACD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sacd_pkg.sv
// Shared constants, row and result types of the cache directory.
// Used by every RTL module of the block; depends on nothing.
`default_nettype none

package sacd_pkg;

    localparam int WAYS             = 8;
    localparam int SET_INDEX_BITS   = 6;
    localparam int LINE_OFFSET_BITS = 6;
    localparam int ADDRESS_BITS     = 32;
    localparam int AGE_BITS         = 16;
    localparam int OUT_ADDR_BITS    = 32;

    localparam int NUM_SETS = 1 << SET_INDEX_BITS;
    localparam int TAG_BITS = ADDRESS_BITS - SET_INDEX_BITS - LINE_OFFSET_BITS;
    localparam int WAY_BITS = $clog2(WAYS);

    typedef logic [SET_INDEX_BITS-1:0] set_t;
    typedef logic [TAG_BITS-1:0]       tag_t;
    typedef logic [AGE_BITS-1:0]       age_t;
    typedef logic [WAY_BITS-1:0]       way_idx_t;

    localparam age_t AGE_MAX = '1;

    typedef enum logic [1:0] {
        STATUS_HIT   = 2'd0,
        STATUS_FILL  = 2'd1,
        STATUS_EVICT = 2'd2
    } status_t;

    typedef struct packed {
        tag_t tag;
        logic valid;
        logic dirty;
        age_t age;
    } way_entry_t;

    typedef way_entry_t [WAYS-1:0] row_t;

    typedef struct packed {
        logic en;
        set_t set;
        row_t row;
    } dir_wr_t;

    typedef struct packed {
        status_t                  status;
        way_idx_t                 way;
        logic                     fill;
        logic                     wb_needed;
        logic [OUT_ADDR_BITS-1:0] wb_addr;
    } lookup_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sacd_dir_mem.sv
// Directory memory: one row of all ways per set, registered read.
// Per-row valid flops make unwritten rows read as the reset row. Uses sacd_pkg.
`default_nettype none

module sacd_dir_mem (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              rd_en,
    input  sacd_pkg::set_t   rd_set,
    input  sacd_pkg::dir_wr_t wr,
    output sacd_pkg::row_t   rd_row
);
    import sacd_pkg::*;

    row_t                mem_array [NUM_SETS];
    row_t                rd_data_reg;
    logic                rd_row_valid_reg;
    logic [NUM_SETS-1:0] row_written_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_array[wr.set] <= wr.row;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_set];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_written_reg  <= '0;
            rd_row_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                row_written_reg[wr.set] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_row_valid_reg <= row_written_reg[rd_set];
            end
        end
    end

    assign rd_row = rd_row_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/sacd_way_select.sv
// Per-access update of one set row: age, tag match, victim choice, new row.
// Pure logic between the memory read register and the write port. Uses sacd_pkg.
`default_nettype none

module sacd_way_select (
    input  sacd_pkg::row_t        row_in,
    input  sacd_pkg::tag_t        tag,
    input  sacd_pkg::set_t        set,
    input  wire                   is_write,
    output sacd_pkg::row_t        row_out,
    output sacd_pkg::lookup_res_t res
);
    import sacd_pkg::*;

    row_t     aged_row;
    logic     hit;
    way_idx_t hit_way;
    logic     have_inv;
    way_idx_t inv_way;
    way_idx_t oldest_way;
    age_t     oldest_age;
    way_idx_t target;
    tag_t     victim_tag;
    logic     victim_dirty;
    logic [ADDRESS_BITS-1:0] victim_addr;

    always_comb
    begin
        aged_row   = row_in;
        hit        = 1'b0;
        hit_way    = '0;
        have_inv   = 1'b0;
        inv_way    = '0;
        oldest_way = '0;
        oldest_age = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (row_in[w].age != AGE_MAX)
            begin
                aged_row[w].age = AGE_BITS'(row_in[w].age + 1'b1);
            end
            if (w == 0 || aged_row[w].age > oldest_age)
            begin
                oldest_way = WAY_BITS'(w);
                oldest_age = aged_row[w].age;
            end
            if (!row_in[w].valid && !have_inv)
            begin
                have_inv = 1'b1;
                inv_way  = WAY_BITS'(w);
            end
            if (row_in[w].valid && row_in[w].tag == tag && !hit)
            begin
                hit     = 1'b1;
                hit_way = WAY_BITS'(w);
            end
        end
    end

    assign victim_tag   = row_in[oldest_way].tag;
    assign victim_dirty = row_in[oldest_way].dirty;
    assign victim_addr  = {victim_tag, set, {LINE_OFFSET_BITS{1'b0}}};

    always_comb
    begin
        row_out       = aged_row;
        res.fill      = !hit;
        res.wb_needed = 1'b0;
        res.wb_addr   = '0;
        if (hit)
        begin
            target     = hit_way;
            res.status = STATUS_HIT;
            row_out[target].age   = '0;
            row_out[target].dirty = row_in[target].dirty | is_write;
        end
        else
        begin
            if (have_inv)
            begin
                target     = inv_way;
                res.status = STATUS_FILL;
            end
            else
            begin
                target     = oldest_way;
                res.status = STATUS_EVICT;
                if (victim_dirty)
                begin
                    res.wb_needed = 1'b1;
                    res.wb_addr   = OUT_ADDR_BITS'(victim_addr);
                end
            end
            row_out[target].tag   = tag;
            row_out[target].valid = 1'b1;
            row_out[target].dirty = is_write;
            row_out[target].age   = '0;
        end
        res.way = target;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/set_assoc_lru_cache_directory_unit.sv
// Top level of the cache directory: handshakes, sequencer, output register.
// Instantiates sacd_dir_mem and sacd_way_select; uses sacd_pkg and the defines header.
//
//   channel | signals                                     | dir
//   --------+---------------------------------------------+-----
//   in      | in_valid, in_ready, command, address        | in
//   out     | out_valid, out_ready, status, way_used,     | out
//           | fill_needed, writeback_needed,              |
//           | writeback_line_address                      |
//
// An access reads the directory row when the beat is accepted, then, in the lookup
// state, updates the row, writes it back and loads the result register.
// The next beat is taken only once the write-back is done.
// A result held by out_ready low stalls a pending update in its lookup cycle.
// Reset clears every row to invalid at once; no clearing pass.
`default_nettype none

`include "set_assoc_lru_cache_directory_unit_defines.svh"

module set_assoc_lru_cache_directory_unit (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire                                  command,
    input  wire  [31:0]                          address,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic [1:0]                           status,
    output logic [sacd_pkg::WAY_BITS-1:0]        way_used,
    output logic                                 fill_needed,
    output logic                                 writeback_needed,
    output logic [sacd_pkg::OUT_ADDR_BITS-1:0]   writeback_line_address
);
    import sacd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_LOOKUP = 2'b10
    } state_t;

    state_t      state_reg, state_next;
    logic        cmd_reg;
    set_t        set_reg;
    tag_t        tag_reg;
    logic        out_valid_reg, out_valid_next;
    lookup_res_t out_res_reg;
    logic        accept;
    logic        done;
    set_t        in_set;
    tag_t        in_tag;
    row_t        rd_row;
    row_t        new_row;
    lookup_res_t res;
    dir_wr_t     wr;

    assign in_set = address[LINE_OFFSET_BITS +: SET_INDEX_BITS];
    assign in_tag = address[LINE_OFFSET_BITS + SET_INDEX_BITS +: TAG_BITS];

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign done     = (state_reg == ST_LOOKUP) && (!out_valid_reg || out_ready);

    sacd_dir_mem u_dir_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (accept),
        .rd_set (in_set),
        .wr     (wr),
        .rd_row (rd_row)
    );

    sacd_way_select u_way_select (
        .row_in   (rd_row),
        .tag      (tag_reg),
        .set      (set_reg),
        .is_write (cmd_reg),
        .row_out  (new_row),
        .res      (res)
    );

    assign wr.en  = done;
    assign wr.set = set_reg;
    assign wr.row = new_row;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (done)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            set_reg <= in_set;
            tag_reg <= in_tag;
        end
        if (done)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid              = out_valid_reg;
    assign status                 = out_res_reg.status;
    assign way_used               = out_res_reg.way;
    assign fill_needed            = out_res_reg.fill;
    assign writeback_needed       = out_res_reg.wb_needed;
    assign writeback_line_address = out_res_reg.wb_addr;

    `SACD_ASSERT_NEXT(a_accept_to_lookup, accept, state_reg == ST_LOOKUP, "accept did not start lookup")
    `SACD_ASSERT_NEXT(a_done_loads_out, done, out_valid_reg, "finished lookup left no result")
    `SACD_ASSERT_NEXT(a_blocked_lookup_holds, (state_reg == ST_LOOKUP) && out_valid_reg && !out_ready, state_reg == ST_LOOKUP, "lookup advanced over held result")
    `SACD_ASSERT_NOW(a_fill_matches_status, out_valid_reg, fill_needed == (out_res_reg.status != STATUS_HIT), "fill flag disagrees with status")
    `SACD_ASSERT_NOW(a_wb_only_on_evict, out_valid_reg && writeback_needed, out_res_reg.status == STATUS_EVICT, "writeback without eviction")

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Testbench for set_assoc_lru_cache_directory_unit: directed, hot-way and random accesses.
// Predicts every lookup result from its own copy of the tag, valid, dirty and age arrays.
// Depends on sacd_pkg and the RTL of the block only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sacd_pkg::*;

    localparam logic CMD_READ       = 1'b0;
    localparam logic CMD_WRITE      = 1'b1;
    localparam int   WATCHDOG_LIMIT = 4000;
    localparam int   HOT_HITS       = 40;
    localparam int   PHASE_ITEMS    = 245;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic                     command;
    logic [31:0]              address;
    logic                     out_valid;
    logic                     out_ready;
    logic [1:0]               status;
    logic [WAY_BITS-1:0]      way_used;
    logic                     fill_needed;
    logic                     writeback_needed;
    logic [OUT_ADDR_BITS-1:0] writeback_line_address;

    tag_t dir_tag   [NUM_SETS][WAYS];
    bit   dir_valid [NUM_SETS][WAYS];
    bit   dir_dirty [NUM_SETS][WAYS];
    age_t dir_age   [NUM_SETS][WAYS];

    lookup_res_t expected_lookups[$];
    int          error_count;
    bit          tx_idle_en;
    bit          rx_idle_en;

    set_assoc_lru_cache_directory_unit uut (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .in_valid               (in_valid),
        .in_ready               (in_ready),
        .command                (command),
        .address                (address),
        .out_valid              (out_valid),
        .out_ready              (out_ready),
        .status                 (status),
        .way_used               (way_used),
        .fill_needed            (fill_needed),
        .writeback_needed       (writeback_needed),
        .writeback_line_address (writeback_line_address)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] line_addr(input tag_t t, input set_t s, input int offset);
        return {t, s, LINE_OFFSET_BITS'(offset)};
    endfunction

    function automatic lookup_res_t lookup_directory(input logic is_write, input logic [31:0] addr);
        set_t        s;
        tag_t        t;
        way_idx_t    oldest;
        way_idx_t    first_free;
        way_idx_t    hit_way;
        way_idx_t    target;
        age_t        oldest_age;
        bit          have_free;
        bit          hit;
        lookup_res_t r;
        s          = addr[LINE_OFFSET_BITS +: SET_INDEX_BITS];
        t          = addr[LINE_OFFSET_BITS + SET_INDEX_BITS +: TAG_BITS];
        oldest     = '0;
        first_free = '0;
        hit_way    = '0;
        oldest_age = '0;
        have_free  = 1'b0;
        hit        = 1'b0;
        r          = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (dir_age[s][w] != AGE_MAX)
                dir_age[s][w] = dir_age[s][w] + 1'b1;
            if (w == 0 || dir_age[s][w] > oldest_age)
            begin
                oldest     = way_idx_t'(w);
                oldest_age = dir_age[s][w];
            end
            if (!dir_valid[s][w] && !have_free)
            begin
                have_free  = 1'b1;
                first_free = way_idx_t'(w);
            end
            if (dir_valid[s][w] && dir_tag[s][w] == t && !hit)
            begin
                hit     = 1'b1;
                hit_way = way_idx_t'(w);
            end
        end
        if (hit)
        begin
            target   = hit_way;
            r.status = STATUS_HIT;
            dir_age[s][target] = '0;
            if (is_write)
                dir_dirty[s][target] = 1'b1;
        end
        else
        begin
            if (have_free)
            begin
                target   = first_free;
                r.status = STATUS_FILL;
            end
            else
            begin
                target   = oldest;
                r.status = STATUS_EVICT;
                if (dir_dirty[s][target])
                begin
                    r.wb_needed = 1'b1;
                    r.wb_addr   = {dir_tag[s][target], s, LINE_OFFSET_BITS'(0)};
                end
            end
            dir_tag[s][target]   = t;
            dir_valid[s][target] = 1'b1;
            dir_dirty[s][target] = is_write;
            dir_age[s][target]   = '0;
        end
        r.way  = target;
        r.fill = !hit;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        lookup_res_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_lookups.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, expected none, actual status %0h",
                             $time, status);
                    error_count++;
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("way_used", 32'(want.way), 32'(way_used));
                    check_field("fill_needed", 32'(want.fill), 32'(fill_needed));
                    check_field("writeback_needed", 32'(want.wb_needed), 32'(writeback_needed));
                    check_field("writeback_line_address", want.wb_addr, writeback_line_address);
                end
            end
            if (in_valid && in_ready)
                expected_lookups.push_back(lookup_directory(command, address));
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_idle_en && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic send_access(input logic cmd, input logic [31:0] addr);
        in_valid <= 1'b1;
        command  <= cmd;
        address  <= addr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic drain_lookups();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_lookups.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic test_directed_extremes();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_access(CMD_READ, 32'h0000_0000);
        send_access(CMD_WRITE, 32'hFFFF_FFFF);
        send_access(CMD_READ, 32'hFFFF_FFC0);
        send_access(CMD_WRITE, 32'h0000_003F);
        for (int w = 1; w < WAYS; w++)
            send_access((w % 2) ? CMD_WRITE : CMD_READ, line_addr(tag_t'(w), set_t'(0), 0));
        send_access(CMD_READ, line_addr(tag_t'(8), set_t'(0), 21));
        send_access(CMD_WRITE, line_addr(tag_t'(1), set_t'(0), 7));
        send_access(CMD_READ, line_addr(tag_t'(9), set_t'(0), 63));
        for (int w = 1; w < WAYS; w++)
            send_access(CMD_READ, line_addr(tag_t'(w), set_t'(NUM_SETS - 1), 32));
        send_access(CMD_READ, line_addr(tag_t'(0), set_t'(NUM_SETS - 1), 0));
        drain_lookups();
    endtask

    task automatic test_hot_way_eviction();
        set_t s;
        s = set_t'(21);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int w = 0; w < WAYS; w++)
            send_access((w == 3) ? CMD_WRITE : CMD_READ,
                        line_addr(tag_t'('h100 + w), s, $urandom_range(0, 63)));
        for (int n = 0; n < HOT_HITS; n++)
            send_access(CMD_READ, line_addr(tag_t'('h107), s, $urandom_range(0, 63)));
        for (int w = 0; w < 5; w++)
            send_access(CMD_READ, line_addr(tag_t'('h200 + w), s, 0));
        drain_lookups();
    endtask

    task automatic test_random_traffic();
        set_t        hot_sets[4];
        tag_t        hot_tags[12];
        logic [31:0] addr;
        for (int phase = 0; phase < 4; phase++)
        begin
            foreach (hot_sets[k])
                hot_sets[k] = set_t'($urandom);
            foreach (hot_tags[k])
                hot_tags[k] = tag_t'($urandom);
            tx_idle_en = (phase < 3);
            rx_idle_en = (phase < 3);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (phase < 3 && i % 50 == 0)
                begin
                    tx_idle_en = ($urandom_range(0, 3) != 0);
                    rx_idle_en = ($urandom_range(0, 3) != 0);
                end
                if ($urandom_range(0, 99) < 12)
                    addr = $urandom;
                else
                    addr = line_addr(hot_tags[$urandom_range(0, 11)],
                                     hot_sets[$urandom_range(0, 3)], $urandom_range(0, 63));
                send_access(logic'($urandom_range(0, 1)), addr);
            end
            drain_lookups();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        command     = CMD_READ;
        address     = '0;
        error_count = 0;
        tx_idle_en  = 1'b0;
        rx_idle_en  = 1'b0;
        for (int s = 0; s < NUM_SETS; s++)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                dir_tag[s][w]   = '0;
                dir_valid[s][w] = 1'b0;
                dir_dirty[s][w] = 1'b0;
                dir_age[s][w]   = '0;
            end
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_hot_way_eviction();
        test_random_traffic();

        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
